### hw/rtl/text_cell_glyph_renderer_macros.svh
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer_macros.svh
// Assertion macros shared by the checker of the text cell renderer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CELL_GLYPH_RENDERER_MACROS_SVH

// Clocked property, disabled during reset.
`define TCGR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen at a clock edge.
`define TCGR_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### hw/rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Constants and types of the text cell glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int COLUMNS     = 128;
	localparam int ROWS        = 64;
	localparam int GLYPH_ROWS  = 14;
	localparam int GLYPH_WIDTH = 8;

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int CELL_AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int COL_AW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LINE_W   = 4;
	localparam int GLYPH_AW = 12;

	typedef enum logic [1:0] {
		REQ_CELL  = 2'd0,
		REQ_GLYPH = 2'd1,
		REQ_INVAL = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CHECK = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	// Lookup result of the cell copy store.
	typedef struct packed {
		logic valid;
		logic same;
	} cell_status_t;

	// Control of the row engine.
	typedef struct packed {
		logic load;
		logic step;
	} row_ctrl_t;

endpackage

### hw/rtl/tcgr_cell_store.sv
// ----------------------------------------------------------------------------
// tcgr_cell_store
// Stored copy of every cell plus valid bits kept one memory word per row,
// qualified by a per-row valid flop so an invalidate clears all rows at once.
// ----------------------------------------------------------------------------
module tcgr_cell_store import tcgr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                lookup,
	input  logic [6:0]          lk_col,
	input  logic [5:0]          lk_row,
	input  logic [6:0]          cur_col,
	input  logic [5:0]          cur_row,
	input  logic [15:0]         cur_word,
	input  logic                commit,
	input  logic                clear_all,
	output cell_status_t        status
);

	logic [15:0]        prev_mem [CELLS];
	logic [COLUMNS-1:0] vmask_mem [ROWS];
	logic [ROWS-1:0]    row_valid_q;

	logic [15:0]        prev_rd_q;
	logic [COLUMNS-1:0] vmask_rd_q;
	logic               rowv_rd_q;

	logic [CELL_AW-1:0] lk_idx;
	logic [CELL_AW-1:0] cur_idx;
	logic [COLUMNS-1:0] new_mask;

	assign lk_idx  = CELL_AW'(32'(lk_row) * COLUMNS + 32'(lk_col));
	assign cur_idx = CELL_AW'(32'(cur_row) * COLUMNS + 32'(cur_col));

	// A row whose flag is clear holds no valid cell whatever its mask says.
	always_comb begin
		new_mask = rowv_rd_q ? vmask_rd_q : '0;
		new_mask[cur_col[COL_AW-1:0]] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (lookup) begin
			prev_rd_q  <= prev_mem[lk_idx];
			vmask_rd_q <= vmask_mem[lk_row[ROW_AW-1:0]];
		end
		if (commit) begin
			prev_mem[cur_idx]                <= cur_word;
			vmask_mem[cur_row[ROW_AW-1:0]]   <= new_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rowv_rd_q   <= 1'b0;
		end else begin
			if (lookup)
				rowv_rd_q <= row_valid_q[lk_row[ROW_AW-1:0]];
			if (clear_all)
				row_valid_q <= '0;
			else if (commit)
				row_valid_q[cur_row[ROW_AW-1:0]] <= 1'b1;
		end
	end

	assign status.valid = rowv_rd_q & vmask_rd_q[cur_col[COL_AW-1:0]];
	assign status.same  = (prev_rd_q == cur_word);

endmodule

### hw/rtl/tcgr_glyph_store.sv
// ----------------------------------------------------------------------------
// tcgr_glyph_store
// Glyph bitmap memory, 256 glyphs of sixteen bytes, registered read.
// ----------------------------------------------------------------------------
module tcgr_glyph_store import tcgr_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [GLYPH_AW-1:0] waddr,
	input  logic [7:0]          wdata,
	input  logic [GLYPH_AW-1:0] raddr,
	output logic [7:0]          rdata
);

	logic [7:0] mem [2**GLYPH_AW];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/tcgr_row_unit.sv
// ----------------------------------------------------------------------------
// tcgr_row_unit
// Row engine reused for every pixel row of a cell: advances the line count
// and pixel line, and expands one glyph byte into eight color indices.
// ----------------------------------------------------------------------------
module tcgr_row_unit import tcgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  row_ctrl_t         ctrl,
	input  logic [5:0]        cell_row,
	input  logic [7:0]        bits,
	input  logic [3:0]        fg,
	input  logic [3:0]        bg,
	output logic [LINE_W-1:0] line,
	output logic [9:0]        y,
	output logic              last,
	output logic [31:0]       word
);

	logic [LINE_W-1:0] line_q;
	logic [9:0]        y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			y_q    <= '0;
		end else if (ctrl.load) begin
			line_q <= '0;
			y_q    <= 10'(32'(cell_row) * GLYPH_ROWS);
		end else if (ctrl.step) begin
			line_q <= line_q + LINE_W'(1);
			y_q    <= y_q + 10'd1;
		end
	end

	// Leftmost pixel comes from bit 7 and lands in the top nibble.
	always_comb begin
		for (int i = 0; i < GLYPH_WIDTH; i++)
			word[4*i +: 4] = bits[i] ? fg : bg;
	end

	assign line = line_q;
	assign y    = y_q;
	assign last = (line_q == LINE_W'(GLYPH_ROWS - 1));

endmodule

### hw/rtl/text_cell_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer
// Text-mode character renderer that redraws only cells that changed.
// ----------------------------------------------------------------------------
// Use: drive req_type and the fields, raise start; the item is taken at the
// edge where start is high and busy is low. Glyph loads and invalidates keep
// busy low. An in-range cell item raises busy for its lookup state; if the
// cell is unchanged busy drops after it. A changed cell then emits fourteen
// rows on consecutive cycles, each shown for one cycle with row_strobe high,
// the last with last_row set. The row timing is set by the one glyph store
// read port and the single row engine, one row per cycle.
// The receiver cannot stall: every strobed row must be taken as it appears.
// Reset clears the sequencer and every row valid flag, so each cell draws on
// its first update; glyph contents are undefined until loaded. Invalidate
// clears all row flags at once.
// ----------------------------------------------------------------------------
module text_cell_glyph_renderer import tcgr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [6:0]  cell_column,
	input  logic [5:0]  cell_row,
	input  logic [7:0]  char_code,
	input  logic [3:0]  fg_color,
	input  logic [3:0]  bg_color,
	input  logic [3:0]  glyph_row,
	input  logic [7:0]  glyph_byte,
	output logic        row_strobe,
	output logic [9:0]  pixel_x,
	output logic [9:0]  pixel_y,
	output logic [31:0] pixels,
	output logic        last_row
);

	state_t state_q;

	logic [6:0] col_q;
	logic [5:0] row_q;
	logic [7:0] code_q;
	logic [3:0] fg_q;
	logic [3:0] bg_q;

	logic         accept;
	logic         in_range;
	logic         lookup;
	logic         commit;
	logic         clear_all;
	logic         glyph_we;
	cell_status_t status;
	row_ctrl_t    rctl;

	logic [LINE_W-1:0]   line;
	logic [LINE_W-1:0]   rd_line;
	logic [GLYPH_AW-1:0] glyph_raddr;
	logic [7:0]          glyph_bits;
	logic                last;

	assign accept    = start & ~busy;
	assign in_range  = (32'(cell_column) < COLUMNS) && (32'(cell_row) < ROWS);
	assign lookup    = accept && (req_t'(req_type) == REQ_CELL) && in_range;
	assign glyph_we  = accept && (req_t'(req_type) == REQ_GLYPH);
	assign clear_all = accept && (req_t'(req_type) == REQ_INVAL);
	assign commit    = (state_q == ST_CHECK) && !(status.valid && status.same);

	assign rctl.load = (state_q == ST_CHECK);
	assign rctl.step = (state_q == ST_EMIT);

	// Fetch one glyph line ahead: line 1 during the check, then line + 2.
	assign rd_line     = (state_q == ST_CHECK) ? LINE_W'(1) : line + LINE_W'(2);
	assign glyph_raddr = {code_q, rd_line};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (lookup)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= commit ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q  <= cell_column;
			row_q  <= cell_row;
			code_q <= char_code;
			fg_q   <= fg_color;
			bg_q   <= bg_color;
		end
	end

	tcgr_cell_store u_cells (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup    (lookup),
		.lk_col    (cell_column),
		.lk_row    (cell_row),
		.cur_col   (col_q),
		.cur_row   (row_q),
		.cur_word  ({bg_q, fg_q, code_q}),
		.commit    (commit),
		.clear_all (clear_all),
		.status    (status)
	);

	tcgr_glyph_store u_glyphs (
		.clk   (clk),
		.we    (glyph_we),
		.waddr ({char_code, glyph_row}),
		.wdata (glyph_byte),
		.raddr (glyph_raddr),
		.rdata (glyph_bits)
	);

	tcgr_row_unit u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rctl),
		.cell_row (row_q),
		.bits     (glyph_bits),
		.fg       (fg_q),
		.bg       (bg_q),
		.line     (line),
		.y        (pixel_y),
		.last     (last),
		.word     (pixels)
	);

	assign busy       = (state_q != ST_IDLE);
	assign row_strobe = (state_q == ST_EMIT);
	assign pixel_x    = {col_q, 3'b000};
	assign last_row   = row_strobe & last;

endmodule

### hw/rtl/tcgr_checker.sv
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks of the text cell renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_cell_glyph_renderer_macros.svh"

module tcgr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       row_strobe,
	input logic [9:0] pixel_x,
	input logic [9:0] pixel_y,
	input logic       last_row
);

	// Rows only come out while an item is in work.
	`TCGR_NEVER(a_strobe_idle, row_strobe && !busy, "row strobe while not busy")
	// The lookup cycle always separates an accepted item from its first row.
	`TCGR_ASSERT(a_no_row_after_accept, start && !busy |=> !row_strobe,
		"row right after accept")
	// Rows of one cell are contiguous and step one pixel line down.
	`TCGR_ASSERT(a_rows_contiguous, row_strobe && !last_row |=>
		row_strobe && pixel_x == $past(pixel_x) && pixel_y == $past(pixel_y) + 10'd1,
		"cell rows not contiguous")
	// The last row ends the item.
	`TCGR_ASSERT(a_last_ends, row_strobe && last_row |=> !busy && !row_strobe,
		"item continues after last row")

endmodule

bind text_cell_glyph_renderer tcgr_checker u_tcgr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.row_strobe (row_strobe),
	.pixel_x    (pixel_x),
	.pixel_y    (pixel_y),
	.last_row   (last_row)
);

### bench/text_cell_glyph_renderer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer_test
// Self-checking bench for the text cell glyph renderer.
// ----------------------------------------------------------------------------
// Loads a few glyphs, walks a short stimulus table that covers the corner
// cells, unchanged cells, invalidates, hidden glyph rows and the unused
// request code, then runs a random mix that mostly stays on a small set
// of cells so that redraws and skipped updates both happen often. A shadow
// copy of the cell store and glyph memory predicts every pixel row. Cells
// only use glyphs whose shown rows have all been loaded.
// ----------------------------------------------------------------------------
module text_cell_glyph_renderer_test;
	import tcgr_pkg::*;

	localparam int DIRECTED_N   = 21;
	localparam int RANDOM_ITEMS = 200;
	localparam int POOL_N       = 12;

	typedef struct packed {
		req_t       kind;
		logic [6:0] col;
		logic [5:0] row;
		logic [7:0] code;
		logic [3:0] fg;
		logic [3:0] bg;
		logic [3:0] grow;
		logic [7:0] gbyte;
	} item_t;

	typedef struct packed {
		item_t       stim;
		logic        typed;
		logic [4:0]  nres;
		logic [9:0]  x;
		logic [9:0]  y0;
		logic [31:0] pix;
	} dir_row_t;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [31:0] pix;
		logic        last;
	} pixel_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [6:0]  cell_column;
	logic [5:0]  cell_row;
	logic [7:0]  char_code;
	logic [3:0]  fg_color;
	logic [3:0]  bg_color;
	logic [3:0]  glyph_row;
	logic [7:0]  glyph_byte;
	logic        row_strobe;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [31:0] pixels;
	logic        last_row;

	// Shadow state of the renderer.
	logic [15:0] cell_copy [CELLS];
	bit          cell_seen [CELLS];
	logic [7:0]  glyph_mem [4096];

	// Stimulus bookkeeping: which glyph bytes hold known data.
	bit          glyph_known [4096];
	bit          code_listed [256];
	logic [7:0]  ready_codes [$];
	logic [6:0]  pool_col [POOL_N];
	logic [5:0]  pool_row [POOL_N];

	pixel_row_t  fresh_rows [$];
	pixel_row_t  expected_rows [$];
	pixel_row_t  head_row;

	int mismatches    = 0;
	int rows_checked  = 0;
	int items_sent    = 0;
	int cells_drawn   = 0;
	int cells_kept    = 0;
	int glyph_writes  = 0;
	int invalidates   = 0;

	// Typed rows carry their pixel rows; the rest are left to the shadow model.
	dir_row_t directed_rows [DIRECTED_N] = '{
		'{'{REQ_CELL,  7'd0,   6'd0,  8'h00, 4'hf, 4'h0, 4'h0, 8'h00},
			1'b1, 5'd14, 10'd0,    10'd0,   32'h0000_0000},
		'{'{REQ_CELL,  7'd127, 6'd63, 8'hff, 4'hf, 4'h0, 4'hf, 8'hff},
			1'b1, 5'd14, 10'd1016, 10'd882, 32'hffff_ffff},
		'{'{REQ_CELL,  7'd127, 6'd63, 8'hff, 4'hf, 4'h0, 4'h0, 8'h00},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd127, 6'd63, 8'hff, 4'ha, 4'h5, 4'h3, 8'h5a},
			1'b1, 5'd14, 10'd1016, 10'd882, 32'haaaa_aaaa},
		'{'{REQ_CELL,  7'd0,   6'd0,  8'h00, 4'hf, 4'h0, 4'hf, 8'hff},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd0,   6'd0,  8'h00, 4'hf, 4'h3, 4'h0, 8'h00},
			1'b1, 5'd14, 10'd0,    10'd0,   32'h3333_3333},
		'{'{REQ_INVAL, 7'd127, 6'd63, 8'hff, 4'hf, 4'hf, 4'hf, 8'hff},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd0,   6'd0,  8'h00, 4'hf, 4'h3, 4'h7, 8'h81},
			1'b1, 5'd14, 10'd0,    10'd0,   32'h3333_3333},
		'{'{REQ_NONE,  7'd127, 6'd63, 8'hff, 4'hf, 4'hf, 4'hf, 8'hff},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		// row 0 and row 15 of a glyph are never shown
		'{'{REQ_GLYPH, 7'd3,   6'd9,  8'hff, 4'h2, 4'h1, 4'h0, 8'h00},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd127, 6'd63, 8'hff, 4'h5, 4'ha, 4'h0, 8'h00},
			1'b1, 5'd14, 10'd1016, 10'd882, 32'h5555_5555},
		'{'{REQ_GLYPH, 7'd0,   6'd0,  8'hff, 4'h0, 4'h0, 4'hf, 8'h00},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd127, 6'd63, 8'hff, 4'h0, 4'hf, 4'h9, 8'h3c},
			1'b1, 5'd14, 10'd1016, 10'd882, 32'h0000_0000},
		'{'{REQ_CELL,  7'd5,   6'd7,  8'ha5, 4'hc, 4'h3, 4'h0, 8'h00},
			1'b0, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd64,  6'd32, 8'ha5, 4'h0, 4'hf, 4'h0, 8'h00},
			1'b0, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd5,   6'd7,  8'ha5, 4'hc, 4'h3, 4'h5, 8'h11},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd5,   6'd7,  8'hff, 4'hc, 4'h3, 4'h0, 8'h00},
			1'b1, 5'd14, 10'd40,   10'd98,  32'hcccc_cccc},
		'{'{REQ_GLYPH, 7'd0,   6'd0,  8'ha5, 4'h0, 4'h0, 4'h1, 8'h81},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		// copy still matches, so the new glyph data stays off screen
		'{'{REQ_CELL,  7'd64,  6'd32, 8'ha5, 4'h0, 4'hf, 4'h0, 8'h00},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_INVAL, 7'd0,   6'd0,  8'h00, 4'h0, 4'h0, 4'h0, 8'h00},
			1'b1, 5'd0,  10'd0,    10'd0,   32'h0},
		'{'{REQ_CELL,  7'd64,  6'd32, 8'ha5, 4'h0, 4'hf, 4'h0, 8'h00},
			1'b0, 5'd0,  10'd0,    10'd0,   32'h0}
	};

	text_cell_glyph_renderer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.char_code   (char_code),
		.fg_color    (fg_color),
		.bg_color    (bg_color),
		.glyph_row   (glyph_row),
		.glyph_byte  (glyph_byte),
		.row_strobe  (row_strobe),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixels      (pixels),
		.last_row    (last_row)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timed out with %0d pixel rows still expected", expected_rows.size());
		$display("FAIL text_cell_glyph_renderer");
		$finish;
	end

	task automatic flag(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", what);
	endtask

	// Apply one item to the shadow state; rows it draws land in fresh_rows.
	function automatic void render_item(input item_t it);
		logic [CELL_AW-1:0] cell_idx;
		logic [15:0]        word;
		logic [7:0]         bits;
		pixel_row_t         r;
		fresh_rows.delete();
		case (it.kind)
			REQ_GLYPH: begin
				glyph_mem[{it.code, it.grow}] = it.gbyte;
				glyph_writes++;
			end
			REQ_INVAL: begin
				foreach (cell_seen[i])
					cell_seen[i] = 1'b0;
				invalidates++;
			end
			REQ_CELL: begin
				cell_idx = CELL_AW'(it.row * COLUMNS + it.col);
				word = {it.bg, it.fg, it.code};
				if (cell_seen[cell_idx] && cell_copy[cell_idx] == word) begin
					cells_kept++;
				end else begin
					cell_copy[cell_idx] = word;
					cell_seen[cell_idx] = 1'b1;
					cells_drawn++;
					// glyph row 0 is skipped: shown lines read rows 1 and up
					for (int line = 0; line < GLYPH_ROWS; line++) begin
						bits = glyph_mem[{it.code, 4'(line + 1)}];
						r.pix = '0;
						for (int p = 0; p < GLYPH_WIDTH; p++)
							r.pix = {r.pix[27:0], bits[7 - p] ? it.fg : it.bg};
						r.x = 10'(it.col * GLYPH_WIDTH);
						r.y = 10'(it.row * GLYPH_ROWS + line);
						r.last = (line == GLYPH_ROWS - 1);
						fresh_rows.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the accept.
	task automatic issue(input item_t it, input logic typed, input logic [4:0] nres,
			input logic [9:0] x, input logic [9:0] y0, input logic [31:0] pix);
		pixel_row_t r;
		bit         full;
		req_type    <= it.kind;
		cell_column <= it.col;
		cell_row    <= it.row;
		char_code   <= it.code;
		fg_color    <= it.fg;
		bg_color    <= it.bg;
		glyph_row   <= it.grow;
		glyph_byte  <= it.gbyte;
		start       <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		render_item(it);
		if (typed) begin
			for (int l = 0; l < nres; l++) begin
				r.x = x;
				r.y = y0 + 10'(l);
				r.pix = pix;
				r.last = (l == nres - 1);
				expected_rows.push_back(r);
			end
		end else begin
			foreach (fresh_rows[i])
				expected_rows.push_back(fresh_rows[i]);
		end
		if (it.kind == REQ_GLYPH) begin
			glyph_known[{it.code, it.grow}] = 1'b1;
			full = 1'b1;
			for (int g = 1; g <= GLYPH_ROWS; g++)
				full &= glyph_known[{it.code, 4'(g)}];
			if (full && !code_listed[it.code]) begin
				code_listed[it.code] = 1'b1;
				ready_codes.push_back(it.code);
			end
		end
		if (it.kind != REQ_NONE)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Hold off until every predicted row has come out.
	task automatic wait_drain();
		start <= 1'b0;
		do @(negedge clk); while (expected_rows.size() != 0);
	endtask

	// Random gaps, with quiet stretches and a quiet tail.
	task automatic maybe_gap(input int n);
		if (!(n >= RANDOM_ITEMS - 60 || (n / 40) % 3 == 2) && $urandom_range(0, 99) < 30)
			idle_for($urandom_range(1, 7));
	endtask

	always @(posedge clk) begin
		if (arst_n && row_strobe === 1'b1) begin
			if (expected_rows.size() == 0) begin
				flag($sformatf("unexpected row x=%0d y=%0d pixels=%08h last=%0b",
					pixel_x, pixel_y, pixels, last_row));
			end else begin
				head_row = expected_rows.pop_front();
				rows_checked++;
				if (pixel_x !== head_row.x || pixel_y !== head_row.y
						|| pixels !== head_row.pix || last_row !== head_row.last)
					flag($sformatf({"row expected x=%0d y=%0d pixels=%08h last=%0b, ",
						"got x=%0d y=%0d pixels=%08h last=%0b"},
						head_row.x, head_row.y, head_row.pix, head_row.last,
						pixel_x, pixel_y, pixels, last_row));
			end
		end
	end

	initial begin
		item_t            it;
		int               k;
		int               pick;
		int               n_rand;
		int               next_drain;
		bit               full_glyph;
		logic [CELL_AW-1:0] cell_idx;

		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = REQ_CELL;
		cell_column = '0;
		cell_row    = '0;
		char_code   = '0;
		fg_color    = '0;
		bg_color    = '0;
		glyph_row   = '0;
		glyph_byte  = '0;

		pool_col[0] = 7'd0;   pool_row[0] = 6'd0;
		pool_col[1] = 7'd127; pool_row[1] = 6'd63;
		pool_col[2] = 7'd0;   pool_row[2] = 6'd63;
		pool_col[3] = 7'd127; pool_row[3] = 6'd0;
		pool_col[4] = 7'd5;   pool_row[4] = 6'd7;
		pool_col[5] = 7'd64;  pool_row[5] = 6'd32;
		for (k = 6; k < POOL_N; k++) begin
			pool_col[k] = 7'($urandom);
			pool_row[k] = 6'($urandom);
		end

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// glyphs used by the table: blank, solid and a striped one
		for (k = 0; k < 48; k++) begin
			it.kind = REQ_GLYPH;
			it.col  = 7'($urandom);
			it.row  = 6'($urandom);
			it.fg   = 4'($urandom);
			it.bg   = 4'($urandom);
			it.grow = k[3:0];
			case (k / 16)
				0: begin
					it.code  = 8'h00;
					it.gbyte = 8'h00;
				end
				1: begin
					it.code  = 8'hff;
					it.gbyte = 8'hff;
				end
				default: begin
					it.code  = 8'ha5;
					it.gbyte = {k[3:0], ~k[3:0]};
				end
			endcase
			issue(it, 1'b1, 5'd0, '0, '0, '0);
		end

		for (k = 0; k < DIRECTED_N; k++) begin
			maybe_gap(0);
			issue(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].nres,
				directed_rows[k].x, directed_rows[k].y0, directed_rows[k].pix);
		end
		wait_drain();

		n_rand = 0;
		next_drain = 75;
		while (n_rand < RANDOM_ITEMS) begin
			if (n_rand >= next_drain) begin
				wait_drain();
				next_drain += 75;
			end
			it.col   = 7'($urandom);
			it.row   = 6'($urandom);
			it.code  = 8'($urandom);
			it.fg    = 4'($urandom);
			it.bg    = 4'($urandom);
			it.grow  = 4'($urandom);
			it.gbyte = 8'($urandom);
			full_glyph = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 62 || pick >= 88) begin
				it.kind = REQ_CELL;
				it.code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
				if (pick < 62) begin
					k = $urandom_range(0, POOL_N - 1);
					it.col = pool_col[k];
					it.row = pool_row[k];
				end
				cell_idx = CELL_AW'(it.row * COLUMNS + it.col);
				// repeat the stored copy now and then to hit the skip path
				if (cell_seen[cell_idx] && $urandom_range(0, 99) < 35)
					{it.bg, it.fg, it.code} = cell_copy[cell_idx];
			end else if (pick < 77) begin
				it.kind = REQ_GLYPH;
				if ($urandom_range(0, 1))
					it.code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
			end else if (pick < 81) begin
				full_glyph = 1'b1;
			end else if (pick < 84) begin
				it.kind = REQ_INVAL;
			end else begin
				it.kind = REQ_NONE;
			end

			if (full_glyph) begin
				it.kind = REQ_GLYPH;
				for (k = 0; k < 16; k++) begin
					it.grow  = k[3:0];
					it.gbyte = 8'($urandom);
					maybe_gap(n_rand);
					issue(it, 1'b0, 5'd0, '0, '0, '0);
					n_rand++;
				end
			end else begin
				maybe_gap(n_rand);
				issue(it, 1'b0, 5'd0, '0, '0, '0);
				if (it.kind != REQ_NONE)
					n_rand++;
			end
		end

		wait_drain();
		repeat (20) @(negedge clk);

		$display("%0d items: %0d cell redraws, %0d unchanged cells, %0d glyph writes, %0d invalidates",
			items_sent, cells_drawn, cells_kept, glyph_writes, invalidates);
		$display("%0d pixel rows compared, %0d glyphs usable, %0d mismatches",
			rows_checked, ready_codes.size(), mismatches);
		if (mismatches == 0)
			$display("PASS text_cell_glyph_renderer");
		else
			$display("FAIL text_cell_glyph_renderer");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_cell_store.sv
hw/rtl/tcgr_glyph_store.sv
hw/rtl/tcgr_row_unit.sv
hw/rtl/text_cell_glyph_renderer.sv
hw/rtl/tcgr_checker.sv
bench/text_cell_glyph_renderer_test.sv
